FILE: sv/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, codes and the session settle function of the treatment
// session controller.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int unsigned CycleTicks = 60000;

    localparam logic [7:0]  TempCompReset   = 8'd32;
    localparam logic [15:0] SaveDelayReset  = 16'd3000;
    localparam logic [11:0] DefPressReset   = 12'd400;
    localparam logic [11:0] TempTargetReset = 12'd608;
    localparam logic [11:0] PressureReset   = 12'd400;
    localparam logic [15:0] CyclesReset     = 16'd5;
    localparam logic [2:0]  ModeMin         = 3'd1;
    localparam logic [2:0]  ModeMax         = 3'd4;

    typedef enum logic [3:0] {
        OP_TICK     = 4'd0,
        OP_MODE     = 4'd1,
        OP_TEMP     = 4'd2,
        OP_PRESSURE = 4'd3,
        OP_LEFT_EN  = 4'd4,
        OP_RIGHT_EN = 4'd5,
        OP_CYCLES   = 4'd6,
        OP_START    = 4'd7,
        OP_STOP     = 4'd8,
        OP_PAUSE    = 4'd9,
        OP_SAVE     = 4'd10,
        OP_FAULT    = 4'd11,
        OP_NONE     = 4'd15
    } op_kind_t;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_PAUSE  = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_UPDATE = 3'd4,
        CMD_STOP   = 3'd5
    } control_cmd_t;

    typedef enum logic [1:0] {
        APP_IDLE    = 2'd0,
        APP_READY   = 2'd1,
        APP_RUNNING = 2'd2,
        APP_ALARM   = 2'd3
    } app_state_t;

    typedef enum logic [1:0] {
        CFG_TEMP_COMP  = 2'd0,
        CFG_SAVE_DELAY = 2'd1,
        CFG_DEF_PRESS  = 2'd2
    } cfg_index_t;

    // classified command as it travels from front to back
    typedef struct packed {
        op_kind_t    kind;
        logic [2:0]  mode;
        logic [11:0] level;
        logic        nz;
        logic [15:0] cycles;
    } item_t;

    typedef struct packed {
        logic        run_req;
        logic        pause_req;
        logic        active;
        logic        paused;
        logic        left_on;
        logic        right_on;
        logic        timer_on;
        logic [31:0] remaining;
        logic [15:0] cycles;
        app_state_t  app;
    } sess_t;

    typedef struct packed {
        sess_t        s;
        control_cmd_t cmd;
    } settle_t;

    localparam sess_t SessReset = '{
        run_req:   1'b0,
        pause_req: 1'b0,
        active:    1'b0,
        paused:    1'b0,
        left_on:   1'b0,
        right_on:  1'b0,
        timer_on:  1'b0,
        remaining: 32'd0,
        cycles:    CyclesReset,
        app:       APP_IDLE
    };

    // bring the controller flags in line with the requests
    function automatic settle_t settle(sess_t s, logic [31:0] arm_val);
        settle_t r;
        r.s   = s;
        r.cmd = CMD_NONE;
        if (s.run_req && (s.left_on || s.right_on))
        begin
            if (s.pause_req)
            begin
                r.s.app = APP_READY;
                if (s.active && !s.paused)
                begin
                    r.s.paused = 1'b1;
                    r.cmd      = CMD_PAUSE;
                end
            end
            else
            begin
                r.s.app = APP_RUNNING;
                if (!s.active)
                begin
                    r.s.active = 1'b1;
                    r.s.paused = 1'b0;
                    r.cmd      = CMD_START;
                    if (!s.timer_on)
                    begin
                        r.s.timer_on = 1'b1;
                        if (s.remaining == 32'd0)
                        begin
                            r.s.remaining = arm_val;
                        end
                    end
                end
                else if (s.paused)
                begin
                    r.s.paused = 1'b0;
                    r.cmd      = CMD_RESUME;
                    if (!s.timer_on && s.remaining != 32'd0)
                    begin
                        r.s.timer_on = 1'b1;
                    end
                end
                else
                begin
                    r.cmd = CMD_UPDATE;
                    if (!s.timer_on)
                    begin
                        r.s.remaining = arm_val;
                        r.s.timer_on  = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (s.active || s.paused)
            begin
                r.s.active = 1'b0;
                r.s.paused = 1'b0;
                r.cmd      = CMD_STOP;
            end
            r.s.app       = APP_READY;
            r.s.timer_on  = 1'b0;
            r.s.remaining = 32'd0;
        end
        return r;
    endfunction

endpackage

FILE: sv/tsc_cmd_if.sv
// ----------------------------------------------------------------------------
// tsc_cmd_if
// Command channel: op code and operand with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsc_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [15:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

FILE: sv/tsc_res_if.sv
// ----------------------------------------------------------------------------
// tsc_res_if
// Result channel: command issued, app state and channel configuration.
// ----------------------------------------------------------------------------
interface tsc_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  ctrl_command;
    logic [1:0]  app_state;
    logic        treatment_running;
    logic        session_done;
    logic        save_request;
    logic [2:0]  mode_now;
    logic [11:0] control_temp;
    logic [11:0] pressure_target;
    logic        left_on;
    logic        right_on;
    logic [15:0] cycle_count;

    modport source (
        output valid, output ctrl_command, output app_state, output treatment_running,
        output session_done, output save_request, output mode_now, output control_temp,
        output pressure_target, output left_on, output right_on, output cycle_count,
        input ready
    );
    modport sink (
        input valid, input ctrl_command, input app_state, input treatment_running,
        input session_done, input save_request, input mode_now, input control_temp,
        input pressure_target, input left_on, input right_on, input cycle_count,
        output ready
    );
endinterface

FILE: sv/treatment_session_controller_top.sv
// ----------------------------------------------------------------------------
// treatment_session_controller_top
// Session controller for a two-channel heat and pressure treatment.
//
//   port     dir   handshake      payload
//   cmd      in    valid/ready    op, value
//   result   out   valid/ready    ctrl_command .. cycle_count
//   cfg_*    in    cfg_we only    cfg_index, cfg_data
//
// one command per cycle sustained while result.ready holds; a queued command is
// popped when the result register is free, and the result is valid from then on
// the back end stalls only on result ready; during such a stall the two-entry
// queue keeps taking commands until it is full, then cmd.ready drops
// the state only moves when a command is taken from the queue, which happens
// only when the result register is free or being emptied in the same cycle
// reset (rst_n low) empties queue, restores setpoint, session and cfg registers
// ----------------------------------------------------------------------------
module treatment_session_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    tsc_cmd_if.sink     cmd,
    tsc_res_if.source   result
);

    logic           full;
    logic           empty;
    logic           push;
    logic           pop;
    tsc_pkg::item_t push_item;
    tsc_pkg::item_t pop_item;

    tsc_front u_front (
        .cmd       (cmd),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    tsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (full),
        .empty     (empty)
    );

    tsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .item      (pop_item),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: sv/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// Accepts commands and classifies them: op decode, mode clamp, level
// saturation, flag and cycle count normalisation.
// ----------------------------------------------------------------------------
module tsc_front (
    tsc_cmd_if.sink         cmd,
    input  logic            full,
    output logic            push,
    output tsc_pkg::item_t  push_item
);

    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;

    always_comb
    begin
        push_item.kind = tsc_pkg::OP_NONE;
        if (cmd.op <= 4'(tsc_pkg::OP_FAULT))
        begin
            push_item.kind = tsc_pkg::op_kind_t'(cmd.op);
        end

        if (cmd.value < 16'(tsc_pkg::ModeMin))
        begin
            push_item.mode = tsc_pkg::ModeMin;
        end
        else if (cmd.value > 16'(tsc_pkg::ModeMax))
        begin
            push_item.mode = tsc_pkg::ModeMax;
        end
        else
        begin
            push_item.mode = cmd.value[2:0];
        end

        // saturate to the 12-bit range
        push_item.level = (cmd.value[15:12] != 4'd0) ? 12'hFFF : cmd.value[11:0];
        push_item.nz    = (cmd.value != 16'd0);
        push_item.cycles = (cmd.value == 16'd0) ? 16'd1 : cmd.value;
    end

endmodule

FILE: sv/tsc_queue.sv
// ----------------------------------------------------------------------------
// tsc_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module tsc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsc_pkg::item_t  push_item,
    input  logic            pop,
    output tsc_pkg::item_t  pop_item,
    output logic            full,
    output logic            empty
);

    tsc_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/tsc_back.sv
// ----------------------------------------------------------------------------
// tsc_back
// Carries out classified commands: session flags, setpoints, pressure slots,
// session and save countdowns, configuration registers and result register.
// ----------------------------------------------------------------------------
module tsc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic            empty,
    input  tsc_pkg::item_t  item,
    output logic            pop,
    tsc_res_if.source       result
);

    // configuration
    logic [7:0]  temp_comp_reg;
    logic [15:0] save_delay_reg;
    logic [11:0] def_press_reg;

    // session state
    tsc_pkg::sess_t sess_reg;
    tsc_pkg::sess_t sess_next;
    logic [2:0]     mode_reg;
    logic [2:0]     mode_next;
    logic [11:0]    temp_target_reg;
    logic [11:0]    temp_target_next;
    logic [11:0]    pressure_reg;
    logic [11:0]    pressure_next;
    logic [11:0]    slot0_reg;
    logic [11:0]    slot0_next;
    logic [11:0]    slot1_reg;
    logic [11:0]    slot1_next;
    logic [15:0]    save_cnt_reg;
    logic [15:0]    save_cnt_next;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    tsc_pkg::control_cmd_t  cmd_reg;
    logic                   done_reg;
    logic                   save_reg;

    tsc_pkg::sess_t        sess;
    tsc_pkg::settle_t      sr;
    tsc_pkg::control_cmd_t cmd;
    logic                  do_settle;
    logic                  done_p;
    logic                  save_p;
    logic [15:0]           cyc_eff;
    logic [31:0]           arm_val;
    logic [11:0]           slot_sel;
    logic [15:0]           save_arm;

    assign pop            = !empty && (!out_valid_reg || result.ready);
    assign out_valid_next = pop || (out_valid_reg && !result.ready);

    always_comb
    begin
        cyc_eff  = (item.kind == tsc_pkg::OP_CYCLES) ? item.cycles : sess_reg.cycles;
        arm_val  = 32'(tsc_pkg::CycleTicks) * 32'(cyc_eff);
        save_arm = (save_delay_reg == 16'd0) ? 16'd1 : save_delay_reg;
        slot_sel = (item.mode <= tsc_pkg::ModeMin) ? slot0_reg : slot1_reg;

        sess             = sess_reg;
        mode_next        = mode_reg;
        temp_target_next = temp_target_reg;
        pressure_next    = pressure_reg;
        slot0_next       = slot0_reg;
        slot1_next       = slot1_reg;
        save_cnt_next    = save_cnt_reg;
        do_settle        = 1'b0;
        done_p           = 1'b0;
        save_p           = 1'b0;

        case (item.kind)
            tsc_pkg::OP_TICK:
            begin
                if (save_cnt_reg != 16'd0)
                begin
                    save_cnt_next = save_cnt_reg - 16'd1;
                    save_p        = (save_cnt_reg == 16'd1);
                end
                if (sess_reg.active && !sess_reg.paused && sess_reg.timer_on)
                begin
                    if (sess_reg.remaining != 32'd0)
                    begin
                        sess.remaining = sess_reg.remaining - 32'd1;
                    end
                    if (sess.remaining == 32'd0)
                    begin
                        sess.run_req   = 1'b0;
                        sess.pause_req = 1'b0;
                        sess.timer_on  = 1'b0;
                        do_settle      = 1'b1;
                        done_p         = 1'b1;
                    end
                end
            end
            tsc_pkg::OP_MODE:
            begin
                mode_next     = item.mode;
                pressure_next = (slot_sel != 12'd0) ? slot_sel : def_press_reg;
                do_settle     = 1'b1;
            end
            tsc_pkg::OP_TEMP:
            begin
                temp_target_next = item.level;
                save_cnt_next    = save_arm;
                do_settle        = 1'b1;
            end
            tsc_pkg::OP_PRESSURE:
            begin
                pressure_next = item.level;
                if (mode_reg <= tsc_pkg::ModeMin)
                begin
                    slot0_next = item.level;
                end
                else
                begin
                    slot1_next = item.level;
                end
                save_cnt_next = save_arm;
                do_settle     = 1'b1;
            end
            tsc_pkg::OP_LEFT_EN:
            begin
                sess.left_on = item.nz;
                do_settle    = 1'b1;
            end
            tsc_pkg::OP_RIGHT_EN:
            begin
                sess.right_on = item.nz;
                do_settle     = 1'b1;
            end
            tsc_pkg::OP_CYCLES:
            begin
                sess.cycles = item.cycles;
                if (sess_reg.active)
                begin
                    sess.remaining = arm_val;
                    sess.timer_on  = 1'b1;
                    do_settle      = 1'b1;
                end
            end
            tsc_pkg::OP_START:
            begin
                if (!sess_reg.left_on && !sess_reg.right_on)
                begin
                    sess.left_on  = 1'b1;
                    sess.right_on = 1'b1;
                end
                sess.pause_req = 1'b0;
                sess.run_req   = 1'b1;
                do_settle      = 1'b1;
            end
            tsc_pkg::OP_STOP:
            begin
                sess.pause_req = 1'b0;
                sess.run_req   = 1'b0;
                do_settle      = 1'b1;
            end
            tsc_pkg::OP_PAUSE:
            begin
                if (!item.nz)
                begin
                    if (sess_reg.run_req && !sess_reg.pause_req)
                    begin
                        sess.pause_req = 1'b1;
                        if (!sess_reg.timer_on)
                        begin
                            sess.remaining = 32'd0;
                        end
                        sess.timer_on = 1'b0;
                        do_settle     = 1'b1;
                    end
                end
                else if (sess_reg.run_req && sess_reg.pause_req)
                begin
                    sess.pause_req = 1'b0;
                    do_settle      = 1'b1;
                end
            end
            tsc_pkg::OP_SAVE:
            begin
                save_p = 1'b1;
            end
            tsc_pkg::OP_FAULT:
            begin
                if (item.nz)
                begin
                    sess.run_req   = 1'b0;
                    sess.pause_req = 1'b0;
                    sess.left_on   = 1'b0;
                    sess.right_on  = 1'b0;
                    do_settle      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        sr        = tsc_pkg::settle(sess, arm_val);
        sess_next = sess;
        cmd       = tsc_pkg::CMD_NONE;
        if (do_settle)
        begin
            sess_next = sr.s;
            cmd       = sr.cmd;
        end
        // a fault overrides the settled state
        if (item.kind == tsc_pkg::OP_FAULT && item.nz)
        begin
            sess_next.app = tsc_pkg::APP_ALARM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_comp_reg  <= tsc_pkg::TempCompReset;
            save_delay_reg <= tsc_pkg::SaveDelayReset;
            def_press_reg  <= tsc_pkg::DefPressReset;
        end
        else if (cfg_we)
        begin
            case (tsc_pkg::cfg_index_t'(cfg_index))
                tsc_pkg::CFG_TEMP_COMP:  temp_comp_reg  <= cfg_data[7:0];
                tsc_pkg::CFG_SAVE_DELAY: save_delay_reg <= cfg_data;
                tsc_pkg::CFG_DEF_PRESS:  def_press_reg  <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sess_reg        <= tsc_pkg::SessReset;
            mode_reg        <= tsc_pkg::ModeMin;
            temp_target_reg <= tsc_pkg::TempTargetReset;
            pressure_reg    <= tsc_pkg::PressureReset;
            slot0_reg       <= tsc_pkg::PressureReset;
            slot1_reg       <= tsc_pkg::PressureReset;
            save_cnt_reg    <= 16'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                sess_reg        <= sess_next;
                mode_reg        <= mode_next;
                temp_target_reg <= temp_target_next;
                pressure_reg    <= pressure_next;
                slot0_reg       <= slot0_next;
                slot1_reg       <= slot1_next;
                save_cnt_reg    <= save_cnt_next;
            end
        end
    end

    // pulses and command are held with the result until it is taken
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg  <= cmd;
            done_reg <= done_p;
            save_reg <= save_p;
        end
    end

    // fields follow the state registers, which move only on pop, and temp_comp_reg
    assign result.valid             = out_valid_reg;
    assign result.ctrl_command      = cmd_reg;
    assign result.app_state         = sess_reg.app;
    assign result.treatment_running = sess_reg.run_req && !sess_reg.pause_req &&
                                      (sess_reg.left_on || sess_reg.right_on);
    assign result.session_done      = done_reg;
    assign result.save_request      = save_reg;
    assign result.mode_now          = mode_reg;
    assign result.control_temp      = (temp_target_reg > 12'(temp_comp_reg)) ?
                                      temp_target_reg - 12'(temp_comp_reg) : 12'd0;
    assign result.pressure_target   = pressure_reg;
    assign result.left_on           = sess_reg.left_on;
    assign result.right_on          = sess_reg.right_on;
    assign result.cycle_count       = sess_reg.cycles;

endmodule
